// File: rtl/core/sas_pkg.sv
package sas_pkg;

   localparam int MAX_PATTERN   = 64;
   localparam int SYMBOL_BITS   = 8;
   localparam int SYMBOL_COUNT  = 1 << SYMBOL_BITS;
   localparam int SYMBOL_PORT_W = 8;
   localparam int CNT_W         = $clog2(MAX_PATTERN + 1);
   localparam int LINE_AW       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int EQ_W          = $clog2(SYMBOL_COUNT + 1);

   typedef logic [1:0] func_type;

   localparam func_type FUNC_CLEAR   = 2'd0;
   localparam func_type FUNC_PATTERN = 2'd1;
   localparam func_type FUNC_TEXT    = 2'd2;
   localparam func_type FUNC_END     = 2'd3;

   typedef struct packed {
      logic load;
      logic clear;
      logic set_ovf;
      logic hist_rd;
      logic rd_old;
      logic hist_wr;
      logic op_pattern;
      logic op_down;
      logic line_rd;
      logic line_wr;
      logic line_fill;
      logic plen_inc;
      logic seen_inc;
      logic head_adv;
      logic hit_check;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic seen_zero;
      logic plen_zero;
      logic plen_full;
      logic filling;
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/sliding_anagram_search.sv
// sliding window anagram search
// request channel: req_valid / req_stall with req_func and req_symbol
//   clear resets all state, pattern byte extends the pattern histogram,
//   text byte slides the window, end of text asks for the verdict
// response channel: rsp_valid / rsp_stall with rsp_found and
//   rsp_pattern_too_long, one response per end of text request only
// a request is taken only in the idle state; the block then stalls until done
//   clear, ignored or overflowing pattern byte: handled in idle, no stall
//   pattern byte: histogram read, then histogram write
//   text byte: with a full window, line read and read/write for the byte leaving;
//   then read/write for the byte entering, unless the pattern is empty; hit check
//   end of text: emit once the output is free, response visible the cycle after
// cost is set by the single histogram memory: every text byte needs a
//   read-modify-write for the byte entering and, once full, the byte leaving
// reset is synchronous and leaves an empty pattern and window; no clearing
//   pass is needed, histogram entries carry valid flags
// one response register sits at the output; while it waits on rsp_stall
//   further requests are still taken, and a second end of text holds until
//   the first response leaves
module sliding_anagram_search (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [sas_pkg::SYMBOL_PORT_W-1:0]  req_symbol,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic                               rsp_pattern_too_long
);
   import sas_pkg::*;

   cmd_type    cmd;
   status_type status;

   sas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sas_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_symbol           (req_symbol),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_pattern_too_long (rsp_pattern_too_long)
   );

endmodule

// File: rtl/core/sas_ram.sv
module sas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sas_ctrl.sv
module sas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  sas_pkg::func_type    req_func,
   output logic                 req_stall,
   input  sas_pkg::status_type  status,
   output sas_pkg::cmd_type     cmd
);
   import sas_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PAT_RD  = 4'd1;
   localparam logic [3:0] S_PAT_WR  = 4'd2;
   localparam logic [3:0] S_LINE_RD = 4'd3;
   localparam logic [3:0] S_OLD_RD  = 4'd4;
   localparam logic [3:0] S_OLD_WR  = 4'd5;
   localparam logic [3:0] S_NEW_RD  = 4'd6;
   localparam logic [3:0] S_NEW_WR  = 4'd7;
   localparam logic [3:0] S_HIT     = 4'd8;
   localparam logic [3:0] S_EMIT    = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               case (req_func)
                  FUNC_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  FUNC_PATTERN: begin
                     if (status.seen_zero) begin
                        if (status.plen_full) begin
                           cmd.set_ovf = 1'b1;
                        end else begin
                           state_in = S_PAT_RD;
                        end
                     end
                  end
                  FUNC_TEXT: begin
                     if (status.plen_zero) begin
                        state_in = S_HIT;
                     end else if (status.filling) begin
                        state_in = S_NEW_RD;
                     end else begin
                        state_in = S_LINE_RD;
                     end
                  end
                  FUNC_END: begin
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PAT_RD: begin
            cmd.hist_rd = 1'b1;
            state_in    = S_PAT_WR;
         end
         S_PAT_WR: begin
            cmd.hist_wr    = 1'b1;
            cmd.op_pattern = 1'b1;
            cmd.plen_inc   = 1'b1;
            state_in       = S_IDLE;
         end
         S_LINE_RD: begin
            cmd.line_rd = 1'b1;
            state_in    = S_OLD_RD;
         end
         S_OLD_RD: begin
            cmd.hist_rd = 1'b1;
            cmd.rd_old  = 1'b1;
            state_in    = S_OLD_WR;
         end
         S_OLD_WR: begin
            cmd.hist_wr = 1'b1;
            cmd.op_down = 1'b1;
            cmd.line_wr = 1'b1;
            state_in    = S_NEW_RD;
         end
         S_NEW_RD: begin
            cmd.hist_rd = 1'b1;
            if (status.filling) begin
               cmd.line_wr   = 1'b1;
               cmd.line_fill = 1'b1;
            end else begin
               cmd.head_adv = 1'b1;
            end
            state_in = S_NEW_WR;
         end
         S_NEW_WR: begin
            cmd.hist_wr  = 1'b1;
            cmd.seen_inc = status.filling;
            state_in     = S_HIT;
         end
         S_HIT: begin
            cmd.hit_check = 1'b1;
            state_in      = S_IDLE;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/sas_dp.sv
module sas_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  sas_pkg::cmd_type                   cmd,
   output sas_pkg::status_type                status,
   input  logic [sas_pkg::SYMBOL_PORT_W-1:0]  req_symbol,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic                               rsp_pattern_too_long
);
   import sas_pkg::*;

   logic [SYMBOL_BITS-1:0]  sym_ff, sym_in;
   logic [CNT_W-1:0]        plen_ff, plen_in;
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic [LINE_AW-1:0]      head_ff, head_in;
   logic [EQ_W-1:0]         equal_ff, equal_in;
   logic                    hit_ff, hit_in;
   logic                    ovf_ff, ovf_in;
   logic [SYMBOL_COUNT-1:0] vld_ff, vld_in;
   logic                    vld_rd_ff, vld_rd_in;
   logic [SYMBOL_BITS-1:0]  hist_addr_ff, hist_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_ptl_ff, rsp_ptl_in;

   logic [SYMBOL_BITS-1:0]  line_rd_data;
   logic [LINE_AW-1:0]      line_wr_addr;
   logic [2*CNT_W-1:0]      hist_rd_data;
   logic [2*CNT_W-1:0]      hist_wr_data;
   logic [SYMBOL_BITS-1:0]  hist_rd_addr;
   logic [CNT_W-1:0]        p_cur, w_cur, p_new, w_new;
   logic                    same_before, same_after;
   logic [CNT_W-1:0]        head_step;
   logic                    match;
   logic                    out_free;

   assign hist_rd_addr = cmd.rd_old ? line_rd_data : sym_ff;
   assign line_wr_addr = cmd.line_fill ? seen_ff[LINE_AW-1:0] : head_ff;

   sas_ram #(
      .WIDTH (2 * CNT_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.hist_wr),
      .wr_addr (hist_addr_ff),
      .wr_data (hist_wr_data),
      .rd_en   (cmd.hist_rd),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   sas_ram #(
      .WIDTH (SYMBOL_BITS),
      .DEPTH (MAX_PATTERN)
   ) u_line (
      .clock   (clock),
      .wr_en   (cmd.line_wr),
      .wr_addr (line_wr_addr),
      .wr_data (sym_ff),
      .rd_en   (cmd.line_rd),
      .rd_addr (head_ff),
      .rd_data (line_rd_data)
   );

   // read-modify-write of one histogram entry
   always_comb begin
      p_cur = vld_rd_ff ? hist_rd_data[2*CNT_W-1:CNT_W] : '0;
      w_cur = vld_rd_ff ? hist_rd_data[CNT_W-1:0] : '0;
      p_new = p_cur;
      w_new = w_cur;
      if (cmd.op_pattern) begin
         p_new = p_cur + 1'b1;
      end else if (!cmd.op_down) begin
         w_new = w_cur + 1'b1;
      end else if (w_cur != '0) begin
         w_new = w_cur - 1'b1;
      end
      same_before  = (p_cur == w_cur);
      same_after   = (p_new == w_new);
      hist_wr_data = {p_new, w_new};
   end

   assign match     = (seen_ff == plen_ff) && (equal_ff == EQ_W'(SYMBOL_COUNT));
   assign head_step = CNT_W'(head_ff) + 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sym_in       = cmd.load ? req_symbol[SYMBOL_BITS-1:0] : sym_ff;
      hist_addr_in = cmd.hist_rd ? hist_rd_addr : hist_addr_ff;
      vld_rd_in    = cmd.hist_rd ? vld_ff[hist_rd_addr] : vld_rd_ff;
      plen_in      = plen_ff;
      seen_in      = seen_ff;
      head_in      = head_ff;
      equal_in     = equal_ff;
      hit_in       = hit_ff;
      ovf_in       = ovf_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ptl_in   = rsp_ptl_ff;

      if (cmd.clear) begin
         plen_in  = '0;
         seen_in  = '0;
         head_in  = '0;
         equal_in = EQ_W'(SYMBOL_COUNT);
         hit_in   = 1'b0;
         ovf_in   = 1'b0;
         vld_in   = '0;
      end else begin
         if (cmd.set_ovf) begin
            ovf_in = 1'b1;
         end
         if (cmd.plen_inc) begin
            plen_in = plen_ff + 1'b1;
         end
         if (cmd.seen_inc) begin
            seen_in = seen_ff + 1'b1;
         end
         if (cmd.head_adv) begin
            head_in = (head_step >= plen_ff) ? '0 : head_step[LINE_AW-1:0];
         end
         if (cmd.hist_wr) begin
            vld_in[hist_addr_ff] = 1'b1;
            if (same_before && !same_after) begin
               equal_in = equal_ff - 1'b1;
            end else if (!same_before && same_after) begin
               equal_in = equal_ff + 1'b1;
            end
         end
         if (cmd.hit_check) begin
            hit_in = hit_ff | match;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff | match;
         rsp_ptl_in   = ovf_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         seen_ff      <= '0;
         head_ff      <= '0;
         equal_ff     <= EQ_W'(SYMBOL_COUNT);
         hit_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         vld_ff       <= '0;
         vld_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         equal_ff     <= equal_in;
         hit_ff       <= hit_in;
         ovf_ff       <= ovf_in;
         vld_ff       <= vld_in;
         vld_rd_ff    <= vld_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      hist_addr_ff <= hist_addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ptl_ff   <= rsp_ptl_in;
   end

   assign status.seen_zero  = (seen_ff == '0);
   assign status.plen_zero  = (plen_ff == '0);
   assign status.plen_full  = (plen_ff >= CNT_W'(MAX_PATTERN));
   assign status.filling    = (seen_ff < plen_ff);
   assign status.out_free   = out_free;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_pattern_too_long = rsp_ptl_ff;

`ifndef ASSERT_OFF
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= plen_ff)
      else $error("text count passed pattern length");

   a_plen_bounded: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= CNT_W'(MAX_PATTERN))
      else $error("pattern length passed its limit");

   a_pattern_before_text: assert property (@(posedge clock) disable iff (reset)
      cmd.plen_inc |-> (seen_ff == '0))
      else $error("pattern grew after text arrived");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.hist_wr |-> $past(cmd.hist_rd))
      else $error("histogram write without preceding read");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("response raised without emit");
`endif

endmodule

// File: tb/sliding_anagram_search_tb.sv
`timescale 1ns / 1ps

module sliding_anagram_search_tb;
   import sas_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int LONG_HOLD    = 400;

   typedef struct packed {
      logic found;
      logic ovf;
   } verdict_type;

   typedef struct packed {
      func_type f;
      logic [7:0] s;
      logic [6:0] rep;
      bit typed;
      bit found;
      bit ovf;
   } plan_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_func;
   logic [SYMBOL_PORT_W-1:0] req_symbol;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_found;
   logic rsp_pattern_too_long;

   // typed verdict carried alongside a request
   bit req_typed, req_typed_found, req_typed_ovf;

   // search state mirror
   logic [CNT_W-1:0] pat_hist [SYMBOL_COUNT];
   logic [CNT_W-1:0] win_hist [SYMBOL_COUNT];
   logic [SYMBOL_BITS-1:0] win_line [MAX_PATTERN];
   logic [LINE_AW-1:0] win_head;
   logic [CNT_W-1:0] pat_len;
   logic [CNT_W-1:0] txt_seen;
   logic [EQ_W-1:0] agree_cnt;
   bit hit_flag, ovf_flag;

   verdict_type verdict_q [$];
   int errors = 0, sent = 0, verdicts = 0, hits = 0, overflows = 0, idle_cycles = 0;
   bit burst, hold_request;

   plan_row_type plan [24] = '{
      '{FUNC_END,     8'h00, 7'd1,  1'b1, 1'b1, 1'b0},  // empty pattern after reset
      '{FUNC_TEXT,    8'hff, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_END,     8'hff, 7'd1,  1'b1, 1'b1, 1'b0},
      '{FUNC_CLEAR,   8'hff, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, 8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, 8'hff, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_TEXT,    8'hff, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_END,     8'h00, 7'd1,  1'b1, 1'b0, 1'b0},  // short text
      '{FUNC_TEXT,    8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_END,     8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, 8'h55, 7'd1,  1'b0, 1'b0, 1'b0},  // pattern after text
      '{FUNC_TEXT,    8'h80, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_TEXT,    8'h01, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_END,     8'h00, 7'd1,  1'b0, 1'b0, 1'b0},  // hit stays latched
      '{FUNC_CLEAR,   8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, 8'haa, 7'd64, 1'b0, 1'b0, 1'b0},
      '{FUNC_PATTERN, 8'h3c, 7'd1,  1'b0, 1'b0, 1'b0},  // pattern overflow
      '{FUNC_END,     8'h00, 7'd1,  1'b1, 1'b0, 1'b1},
      '{FUNC_TEXT,    8'haa, 7'd64, 1'b0, 1'b0, 1'b0},
      '{FUNC_END,     8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_TEXT,    8'h7f, 7'd3,  1'b0, 1'b0, 1'b0},
      '{FUNC_END,     8'hff, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_CLEAR,   8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
      '{FUNC_END,     8'h00, 7'd1,  1'b1, 1'b1, 1'b0}
   };

   sliding_anagram_search i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_symbol           (req_symbol),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_pattern_too_long (rsp_pattern_too_long)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void clear_search();
      foreach (pat_hist[i]) begin
         pat_hist[i] = '0;
         win_hist[i] = '0;
      end
      foreach (win_line[i]) win_line[i] = '0;
      win_head  = '0;
      pat_len   = '0;
      txt_seen  = '0;
      agree_cnt = EQ_W'(SYMBOL_COUNT);
      hit_flag  = 1'b0;
      ovf_flag  = 1'b0;
   endfunction

   function automatic void bump(input logic [SYMBOL_BITS-1:0] sy, input bit in_pat,
                                input bit up);
      bit was, now;
      was = pat_hist[sy] == win_hist[sy];
      if (in_pat) pat_hist[sy] = pat_hist[sy] + 1'b1;
      else if (up) win_hist[sy] = win_hist[sy] + 1'b1;
      else if (win_hist[sy] != 0) win_hist[sy] = win_hist[sy] - 1'b1;
      now = pat_hist[sy] == win_hist[sy];
      if (was && !now) agree_cnt = agree_cnt - 1'b1;
      else if (!was && now) agree_cnt = agree_cnt + 1'b1;
   endfunction

   function automatic bit search_step(input func_type f,
                                      input logic [SYMBOL_PORT_W-1:0] s,
                                      output verdict_type v);
      logic [SYMBOL_BITS-1:0] sy, old;
      sy = s[SYMBOL_BITS-1:0];
      v = '0;
      case (f)
         FUNC_CLEAR: clear_search();
         FUNC_PATTERN: begin
            if (txt_seen == 0) begin
               if (pat_len >= MAX_PATTERN) ovf_flag = 1'b1;
               else begin
                  bump(sy, 1'b1, 1'b1);
                  pat_len = pat_len + 1'b1;
               end
            end
         end
         FUNC_TEXT: begin
            if (pat_len != 0) begin
               if (txt_seen < pat_len) begin
                  win_line[txt_seen[LINE_AW-1:0]] = sy;
                  bump(sy, 1'b0, 1'b1);
                  txt_seen = txt_seen + 1'b1;
               end else begin
                  old = win_line[win_head];
                  bump(old, 1'b0, 1'b0);
                  win_line[win_head] = sy;
                  bump(sy, 1'b0, 1'b1);
                  win_head = (int'(win_head) + 1 >= int'(pat_len)) ? '0 : win_head + 1'b1;
               end
            end
            if (txt_seen == pat_len && agree_cnt == SYMBOL_COUNT) hit_flag = 1'b1;
         end
         default: begin
            v.found = hit_flag || (txt_seen == pat_len && agree_cnt == SYMBOL_COUNT);
            v.ovf   = ovf_flag;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // request and response monitor, watchdog
   always @(posedge clock) begin
      verdict_type v;
      bit moved;
      if (reset) begin
         clear_search();
      end else begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (verdict_q.size() == 0) begin
               $error("response with no verdict pending");
               errors++;
            end else begin
               v = verdict_q.pop_front();
               if (rsp_found !== v.found) begin
                  $error("found: expected %0d, got %0d", v.found, rsp_found);
                  errors++;
               end
               if (rsp_pattern_too_long !== v.ovf) begin
                  $error("pattern_too_long: expected %0d, got %0d", v.ovf,
                         rsp_pattern_too_long);
                  errors++;
               end
               verdicts++;
               if (v.found) hits++;
               if (v.ovf) overflows++;
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if (search_step(req_func, req_symbol, v)) begin
               if (req_typed) begin
                  v.found = req_typed_found;
                  v.ovf   = req_typed_ovf;
               end
               verdict_q.push_back(v);
            end
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // response side back-pressure
   initial begin
      int hold, pct, cyc;
      bit hold_taken;
      rsp_stall  = 1'b0;
      hold_taken = 1'b0;
      hold = 0;
      pct  = 20;
      cyc  = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 256 == 0) begin
            case ($urandom_range(0, 2))
               0: pct = 0;
               1: pct = 25;
               default: pct = 70;
            endcase
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if ($urandom_range(0, 99) < pct) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 19) == 0) hold = $urandom_range(8, 40);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   task automatic rest(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic offer(input func_type f, input logic [7:0] s, input bit typed = 1'b0,
                        input bit tf = 1'b0, input bit to = 1'b0);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_func        <= f;
      req_symbol      <= s;
      req_typed       <= typed;
      req_typed_found <= tf;
      req_typed_ovf   <= to;
      do @(posedge clock); while (req_stall);
      sent++;
      rest(burst ? 0 : pick_gap());
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic text_run(input int count, input logic [7:0] base, input int bits);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 8) offer(FUNC_END, 8'($urandom));
         else if (r < 14) offer(FUNC_PATTERN, 8'($urandom));
         else offer(FUNC_TEXT, base ^ 8'($urandom_range(0, (1 << bits) - 1)));
      end
   endtask

   // mostly clear, pattern, text with an optional anagram of the pattern, verdict; else random requests
   task automatic random_search();
      logic [7:0] pat [0:MAX_PATTERN+7];
      logic [7:0] base, t;
      int bits, plen, used, r, j, k;
      base = 8'($urandom);
      bits = $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(4, 12))
            offer(func_type'($urandom_range(0, 3)), 8'($urandom));
         return;
      end
      if ($urandom_range(0, 7) != 0) offer(FUNC_CLEAR, 8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 4) plen = $urandom_range(MAX_PATTERN - 2, MAX_PATTERN + 6);
      else if (r < 10) plen = 0;
      else plen = $urandom_range(1, 8);
      for (j = 0; j < plen; j++) begin
         pat[j] = base ^ 8'($urandom_range(0, (1 << bits) - 1));
         offer(FUNC_PATTERN, pat[j]);
      end
      used = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      for (j = used - 1; j > 0; j--) begin
         k = $urandom_range(0, j);
         t = pat[j];
         pat[j] = pat[k];
         pat[k] = t;
      end
      text_run($urandom_range(0, 6), base, bits);
      if ($urandom_range(0, 1) == 1)
         for (j = 0; j < used; j++) offer(FUNC_TEXT, pat[j]);
      text_run($urandom_range(0, 6), base, bits);
      offer(FUNC_END, 8'($urandom));
   endtask

   initial begin
      int seq_n;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_CLEAR;
      req_symbol      = '0;
      req_typed       = 1'b0;
      req_typed_found = 1'b0;
      req_typed_ovf   = 1'b0;
      hold_request    = 1'b0;
      burst           = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         for (int k = 0; k < plan[i].rep; k++)
            offer(plan[i].f, plan[i].s + 8'(k), plan[i].typed, plan[i].found, plan[i].ovf);
      drain();

      seq_n = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (seq_n == 8) begin
            // long response hold-off while requests keep coming
            hold_request = 1'b1;
            burst = 1'b1;
            repeat (5) random_search();
            offer(FUNC_END, 8'h00);
            offer(FUNC_END, 8'hff);
            burst = 1'b0;
            drain();
         end else begin
            burst = ($urandom_range(0, 3) == 0);
            random_search();
            if ($urandom_range(0, 3) == 0) drain();
         end
         seq_n++;
      end
      drain();
      repeat (20) @(posedge clock);

      $display("ran %0d random requests in %0d searches after the directed table", sent, seq_n);
      $display("checked %0d verdicts: %0d found, %0d with pattern overflow",
               verdicts, hits, overflows);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
